// File: rtl/core/rgba_2x2_box_downsampler_assert.svh
// Assertion macros shared by the box downsampler RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RGBA_2X2_BOX_DOWNSAMPLER_ASSERT_SVH
`define RGBA_2X2_BOX_DOWNSAMPLER_ASSERT_SVH

// Invariant that holds at every clock edge
`define RBDS_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define RBDS_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rbds_pkg.sv
// Package for the 2x2 box downsampler: constants, types and the lane-wise halving add.
// No dependencies.
package rbds_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W       = 32;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int MIN_WIDTH   = 8;
    localparam int MIN_HEIGHT  = 2;
    localparam int WIDTH_ALIGN = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(8);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(2);

    localparam logic [PIX_W-1:0] LANE_MASK = 32'h7F7F7F7F;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_HOLD,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic done;
    } rbds_cmd_t;

    function automatic logic [PIX_W-1:0] half_add(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        half_add = (a & b) + (((a ^ b) >> 1) & LANE_MASK);
    endfunction

endpackage

// File: rtl/core/rbds_if.sv
// Stream interfaces of the box downsampler: source pixels in, averaged pixels out.
// Depends on rbds_pkg.
interface rbds_pix_if import rbds_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface rbds_res_if import rbds_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             image_done;

    modport source (output valid, output out_pixel, output image_done, input ready);
    modport sink   (input valid, input out_pixel, input image_done, output ready);
endinterface

// File: rtl/core/rbds_line_store.sv
// Line store: single-port synchronous RAM holding the even source row.
// Depends on rbds_pkg.
module rbds_line_store
    import rbds_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [PIX_W-1:0] wdata,
    output logic [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rbds_addr_gen.sv
// Configuration registers, column/row counters and line store access control.
// Depends on rbds_pkg and rgba_2x2_box_downsampler_assert.svh.
`include "rgba_2x2_box_downsampler_assert.svh"

module rbds_addr_gen
    import rbds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    output rbds_cmd_t            cmd,
    output logic [CW-1:0]        addr,
    output logic                 mem_we,
    output logic                 mem_re
);

    localparam int XW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int YW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;

    logic [XW-1:0] w_raw;
    logic [XW-1:0] w_clamp;
    logic [XW-1:0] w_align;
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_raw;
    logic [YW-1:0] h_eff;
    logic [YW-1:0] paired_rows;
    logic [XW-1:0] col_inc;
    logic [YW-1:0] row_inc;
    logic          row_end;
    logic          active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_raw = XW'(width_reg);
        if (w_raw < XW'(MIN_WIDTH))
        begin
            w_clamp = XW'(MIN_WIDTH);
        end
        else if (w_raw > XW'(MAX_WIDTH))
        begin
            w_clamp = XW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_raw;
        end
        w_align = w_clamp & ~XW'(WIDTH_ALIGN - 1);
        w_eff   = (w_align < XW'(MIN_WIDTH)) ? XW'(MIN_WIDTH) : w_align;

        h_raw = YW'(height_reg);
        if (h_raw < YW'(MIN_HEIGHT))
        begin
            h_eff = YW'(MIN_HEIGHT);
        end
        else if (h_raw > YW'(MAX_HEIGHT))
        begin
            h_eff = YW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_raw;
        end
        paired_rows = h_eff & ~YW'(1);

        col_inc = XW'(col_reg) + XW'(1);
        row_inc = YW'(row_reg) + YW'(1);
        row_end = col_inc >= w_eff;
        active  = YW'(row_reg) < paired_rows;

        if (!active)
        begin
            cmd.op = OP_NONE;
        end
        else if (!row_reg[0])
        begin
            cmd.op = OP_STORE;
        end
        else if (!col_reg[0])
        begin
            cmd.op = OP_HOLD;
        end
        else
        begin
            cmd.op = OP_EMIT;
        end
        cmd.done = row_end && (row_inc >= paired_rows);

        if (row_end)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign addr   = col_reg;
    assign mem_we = accept && (cmd.op == OP_STORE);
    assign mem_re = accept && ((cmd.op == OP_HOLD) || (cmd.op == OP_EMIT));

    `RBDS_CHECK(a_col_range, XW'(col_reg) < XW'(MAX_WIDTH), "column count out of range")
    `RBDS_CHECK(a_row_range, YW'(row_reg) < YW'(MAX_HEIGHT), "row count out of range")
    `RBDS_CHECK_IMP(a_emit_odd, accept && (cmd.op == OP_EMIT), col_reg[0] && row_reg[0], "emit off odd row or column")
    `RBDS_CHECK(a_we_re_excl, !(mem_we && mem_re), "line store read and write together")

endmodule

// File: rtl/core/rbds_avg_out.sv
// Averaging stage and output register: vertical and horizontal halving adds per byte lane.
// Depends on rbds_pkg.
module rbds_avg_out
    import rbds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  rbds_cmd_t        cmd,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] rdata,
    input  logic             out_ready,
    output logic             in_ready,
    output logic             out_valid,
    output logic [PIX_W-1:0] out_pixel,
    output logic             out_done
);

    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic             s1_done_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [PIX_W-1:0] held_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_done_reg;

    logic             out_free;
    logic             s1_blocked;
    logic             s1_go;
    logic [PIX_W-1:0] vert;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_blocked = s1_valid_reg && (s1_op_reg == OP_EMIT) && !out_free;
    assign s1_go      = s1_valid_reg && !s1_blocked;
    assign in_ready   = !s1_blocked;
    assign vert       = half_add(rdata, s1_pixel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || s1_blocked;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= cmd.op;
            s1_done_reg  <= cmd.done;
            s1_pixel_reg <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (s1_go && (s1_op_reg == OP_HOLD))
        begin
            held_reg <= vert;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && (s1_op_reg == OP_EMIT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && (s1_op_reg == OP_EMIT))
        begin
            out_pixel_reg <= half_add(held_reg, vert);
            out_done_reg  <= s1_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_done  = out_done_reg;

endmodule

// File: rtl/core/rgba_2x2_box_downsampler.sv
// Top level of the streaming 2x2 box downsampler for four-byte pixels.
// Depends on rbds_pkg, rbds_if, rbds_line_store, rbds_addr_gen and rbds_avg_out.
//
// Usage:
//   pixels  : source words in raster order, one pixel per word.
//   results : one averaged word per 2x2 block; image_done marks the last one.
//   cfg_*   : write image_width (index 0) and image_height (index 1) while idle.
// Throughput: one pixel word per cycle unless a finished block waits for the
//   output register; the single-port line store is written on even rows and
//   read on odd rows. The word that completes a block and its line store read
//   are registered, then averaged into the output register.
// Reset: counters return to the first pixel of an image, width to 8 and
//   height to 2. The line store is not cleared; every entry is written on an
//   even row before the odd row reads it.
// Stall: the output register holds its word while results.ready is low;
//   pixels.ready drops only when a finished block waits behind it, so words
//   that produce no result still flow in. An odd last row yields no result.
module rgba_2x2_box_downsampler
    import rbds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rbds_pix_if.sink             pixels,
    rbds_res_if.source           results
);

    localparam int CW = $clog2(MAX_WIDTH);

    rbds_cmd_t        cmd;
    logic [CW-1:0]    addr;
    logic             mem_we;
    logic             mem_re;
    logic [PIX_W-1:0] rdata;
    logic             in_ready;
    logic             accept;

    assign accept       = pixels.valid && in_ready;
    assign pixels.ready = in_ready;

    rbds_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd),
        .addr      (addr),
        .mem_we    (mem_we),
        .mem_re    (mem_re)
    );

    rbds_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr),
        .wdata (pixels.pixel),
        .rdata (rdata)
    );

    rbds_avg_out u_avg_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .pixel     (pixels.pixel),
        .rdata     (rdata),
        .out_ready (results.ready),
        .in_ready  (in_ready),
        .out_valid (results.valid),
        .out_pixel (results.out_pixel),
        .out_done  (results.image_done)
    );

endmodule

// File: verif/tb_rgba_2x2_box_downsampler.sv
// Testbench for rgba_2x2_box_downsampler: drives pixel words, predicts each 2x2 block average
// and image_done flag (or takes them from a directed table), and compares every result word
// in order. Depends on rbds_pkg and the rbds_pix_if / rbds_res_if stream interfaces of the RTL.
module tb_rgba_2x2_box_downsampler;
    import rbds_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int ITEM_SLACK   = 100;
    localparam int SETTLE_CYC   = 4;
    localparam int TAIL_CYC     = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             done;
    } box_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             exp_on;
        logic [PIX_W-1:0] exp_px;
        logic             exp_done;
    } stim_row_t;

    // 8x2 image at reset size: row 0 then row 1
    localparam stim_row_t DIR_ROWS [16] = '{
        '{32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{32'h00000000, 1'b0, 32'h00000000, 1'b0},
        '{32'h00000000, 1'b0, 32'h00000000, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{32'h00000000, 1'b0, 32'h00000000, 1'b0},
        '{32'h12345678, 1'b0, 32'h00000000, 1'b0},
        '{32'h9ABCDEF0, 1'b0, 32'h00000000, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{32'h00000000, 1'b0, 32'h00000000, 1'b0},
        '{32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{32'h00000000, 1'b1, 32'h7F7F7F7F, 1'b0},
        '{32'h0F1E2D3C, 1'b0, 32'h00000000, 1'b0},
        '{32'h4B5A6978, 1'b0, 32'h00000000, 1'b0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rbds_pix_if pix_ch();
    rbds_res_if res_ch();

    rgba_2x2_box_downsampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    // predictor state
    logic [PIX_W-1:0] line_mem [MAX_W];
    int               col_pos;
    int               row_pos;
    logic [PIX_W-1:0] held_vavg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    box_t             expected_boxes [$];
    logic             tbl_exp_on;
    logic [PIX_W-1:0] tbl_exp_px;
    logic             tbl_exp_done;

    bit gaps_on;
    bit long_hold_req;
    int mismatches;
    int pixels_in;
    int results_out;
    int images_closed;
    int settings_run;
    int long_holds;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [PIX_W-1:0] lane_avg(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [8:0]       s;
        logic [PIX_W-1:0] r;
        for (int i = 0; i < 4; i++)
        begin
            s = a[8*i +: 8] + b[8*i +: 8];
            r[8*i +: 8] = s[8:1];
        end
        return r;
    endfunction

    function automatic int clamp_width(input int raw);
        int w;
        w = raw;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_W) w = MAX_W;
        w = w - (w % WIDTH_ALIGN);
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        return w;
    endfunction

    function automatic int clamp_height(input int raw);
        int h;
        h = raw;
        if (h < MIN_HEIGHT) h = MIN_HEIGHT;
        if (h > MAX_H) h = MAX_H;
        return h;
    endfunction

    task automatic box_predict(input logic [PIX_W-1:0] px, output bit got, output box_t res);
        int               w;
        int               h;
        int               paired;
        bit               row_end;
        logic [PIX_W-1:0] v;
        w       = clamp_width(int'(width_reg));
        h       = clamp_height(int'(height_reg));
        paired  = (h / 2) * 2;
        row_end = (col_pos + 1) >= w;
        got     = 1'b0;
        res     = '0;
        if (row_pos < paired && col_pos < MAX_W)
        begin
            if (row_pos % 2 == 0)
            begin
                line_mem[col_pos] = px;
            end
            else
            begin
                v = lane_avg(line_mem[col_pos], px);
                if (col_pos % 2 == 0)
                begin
                    held_vavg = v;
                end
                else
                begin
                    res.px   = lane_avg(held_vavg, v);
                    res.done = row_end && (row_pos + 1) >= paired;
                    got      = 1'b1;
                end
            end
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        int               r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            p = '0;
        end
        else if (r == 1)
        begin
            p = '1;
        end
        else if (r == 2)
        begin
            for (int i = 0; i < 4; i++)
                p[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else
        begin
            p = $urandom;
        end
        return p;
    endfunction

    task automatic note_mismatch(input string what, input box_t want, input box_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %s: expected px=%08h done=%0b, actual px=%08h done=%0b",
                     what, want.px, want.done, got.px, got.done);
    endtask

    always @(posedge clk)
    begin : scoreboard
        bit   got;
        box_t pred;
        box_t want;
        box_t seen;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            box_predict(pix_ch.pixel, got, pred);
            pixels_in++;
            if (tbl_exp_on)
            begin
                want.px   = tbl_exp_px;
                want.done = tbl_exp_done;
                expected_boxes.push_back(want);
            end
            else if (got)
            begin
                expected_boxes.push_back(pred);
            end
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_out++;
            seen.px   = res_ch.out_pixel;
            seen.done = res_ch.image_done;
            if (seen.done === 1'b1) images_closed++;
            if (expected_boxes.size() == 0)
            begin
                note_mismatch("unexpected word", '0, seen);
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (seen.px !== want.px) note_mismatch("out_pixel", want, seen);
                else if (seen.done !== want.done) note_mismatch("image_done", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : result_sink
        int gap_left;
        int hold_left;
        int g;
        gap_left     = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
                long_holds++;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                res_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    gap_left = g - 1;
                    res_ch.ready <= 1'b0;
                end
                else
                begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic exp_on,
                              input logic [PIX_W-1:0] exp_px, input logic exp_done);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        tbl_exp_on   <= exp_on;
        tbl_exp_px   <= exp_px;
        tbl_exp_done <= exp_done;
        do
            @(posedge clk);
        while (!(pix_ch.valid && pix_ch.ready));
        @(negedge clk);
    endtask

    task automatic settle_block();
        pix_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        @(negedge clk);
    endtask

    task automatic run_phase(input int w_val, input int h_val, input int images,
                             input int extra, input bit pause_mid, output int sent);
        int n;
        int pause_at;
        settle_block();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w_val));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_val));
        settings_run++;
        n        = images * clamp_width(w_val) * clamp_height(h_val) + extra;
        pause_at = pause_mid ? n / 2 : -1;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
            begin
                pix_ch.valid <= 1'b0;
                while (expected_boxes.size() != 0) @(negedge clk);
                @(negedge clk);
            end
            send_pixel(rand_pixel(), 1'b0, '0, 1'b0);
        end
        sent = n;
    endtask

    initial
    begin : stimulus
        int sent;
        int w_val;
        int h_val;
        int img;
        int images;
        int extra;
        int r;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel  = '0;
        tbl_exp_on    = 1'b0;
        tbl_exp_px    = '0;
        tbl_exp_done  = 1'b0;
        long_hold_req = 1'b0;
        gaps_on       = 1'b1;
        mismatches    = 0;
        pixels_in     = 0;
        results_out   = 0;
        images_closed = 0;
        settings_run  = 0;
        long_holds    = 0;
        idle_cycles   = 0;
        col_pos       = 0;
        row_pos       = 0;
        held_vavg     = '0;
        width_reg     = IMAGE_WIDTH_RESET;
        height_reg    = IMAGE_HEIGHT_RESET;
        foreach (line_mem[i]) line_mem[i] = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 16; i++)
            send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].exp_on, DIR_ROWS[i].exp_px,
                       DIR_ROWS[i].exp_done);

        run_phase(0, 0, 1, 0, 1'b0, sent);
        run_phase(7, 1, 1, 0, 1'b0, sent);
        run_phase(15, 3, 2, 0, 1'b0, sent);
        run_phase(23, 5, 1, 0, 1'b1, sent);
        run_phase(4095, 1, 0, 200, 1'b0, sent);
        gaps_on = 1'b0;
        run_phase(2048, 3, 0, 16, 1'b0, sent);
        run_phase(0, 4095, 0, 40, 1'b0, sent);
        gaps_on = 1'b1;
        run_phase(8, 2048, 0, 40, 1'b0, sent);

        // hold the result side off while the sender streams without gaps
        gaps_on = 1'b0;
        settle_block();
        long_hold_req = 1'b1;
        run_phase(8, 8, 6, 0, 1'b0, sent);

        while (pixels_in < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 8) w_val = $urandom_range(8, 48);
            else if (r == 8) w_val = $urandom_range(0, 7);
            else w_val = $urandom_range(49, 160);
            r = $urandom_range(0, 9);
            if (r < 7) h_val = $urandom_range(2, 8);
            else if (r == 7) h_val = $urandom_range(0, 1);
            else h_val = (w_val > 48) ? $urandom_range(2, 4) : $urandom_range(9, 24);
            img    = clamp_width(w_val) * clamp_height(h_val);
            images = $urandom_range(1, 2);
            extra  = ($urandom_range(0, 9) < 3) ? $urandom_range(1, img - 1) : 0;
            if (pixels_in + images * img + extra > RANDOM_ITEMS + ITEM_SLACK)
            begin
                w_val  = MIN_WIDTH;
                h_val  = MIN_HEIGHT;
                images = 1;
                extra  = 0;
            end
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 7) == 0) long_hold_req = 1'b1;
            run_phase(w_val, h_val, images, extra, $urandom_range(0, 9) == 0, sent);
        end

        pix_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge clk);
        repeat (TAIL_CYC) @(negedge clk);
        if (expected_boxes.size() != 0)
        begin
            mismatches++;
            $display("%0d expected result words never arrived", expected_boxes.size());
        end

        $display("Sent %0d pixel words under %0d register settings, checked %0d result words.",
                 pixels_in, settings_run, results_out);
        $display("%0d images closed with image_done, %0d long result-side stalls.",
                 images_closed, long_holds);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
